// ===== src/tblr_pkg.sv =====
// ----------------------------------------------------------------------------
// tblr_pkg : shared types and constants of the square-brush line rasteriser
// Widths of the coordinate, colour and address fields, register indexes and
// the point word that passes from the line engine to the brush emitter.
// ----------------------------------------------------------------------------
package tblr_pkg;

    localparam int COORD_BITS = 12;
    localparam int MAX_BRUSH  = 4;
    localparam int CANVAS_MAX = 1024;

    localparam int BRUSH_W  = 3;
    localparam int CANVAS_W = 11;
    localparam int COLOR_W  = 8;
    localparam int ADDR_W   = 20;
    localparam int PIX_W    = COORD_BITS + 1;
    localparam int SPAN_W   = COORD_BITS + 1;
    localparam int ERR_W    = COORD_BITS + 3;
    // Holds a brush edge length 1..MAX_BRUSH and a pixel index inside the brush.
    localparam int IDX_W    = $clog2(MAX_BRUSH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd2;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CANVAS_W-1:0]          t_canvas;

    // Point to be plotted by one tick, taken before the Bresenham step.
    typedef struct packed {
        t_coord             x;
        t_coord             y;
        logic [COLOR_W-1:0] color;
        logic               done;
        logic               idle;
    } t_plot;

endpackage

// ===== src/tblr_line_engine.sv =====
// ----------------------------------------------------------------------------
// tblr_line_engine : Bresenham line state
// Loads the end points on a start word and steps on each tick word until the
// end point; presents the point of the current tick to the brush emitter.
// ----------------------------------------------------------------------------
module tblr_line_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_tick,
    input  tblr_pkg::t_coord               i_start_x,
    input  tblr_pkg::t_coord               i_start_y,
    input  tblr_pkg::t_coord               i_end_x,
    input  tblr_pkg::t_coord               i_end_y,
    input  logic [tblr_pkg::COLOR_W-1:0]   i_ink,
    output tblr_pkg::t_plot                o_plot
);
    import tblr_pkg::*;

    localparam int E2_W = ERR_W + 1;

    t_coord                    r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [SPAN_W-1:0]         r_span_x, r_span_y;
    logic                      r_neg_x, r_neg_y;
    logic signed [ERR_W-1:0]   r_err;
    logic [COLOR_W-1:0]        r_color;
    logic                      r_active;

    logic signed [SPAN_W-1:0]  diff_x, diff_y;
    logic [SPAN_W-1:0]         abs_x, abs_y;
    logic signed [E2_W-1:0]    e2;
    logic                      step_x, step_y;
    logic                      done;
    logic signed [ERR_W-1:0]   n_err;

    assign done = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);

    assign diff_x = SPAN_W'(i_end_x) - SPAN_W'(i_start_x);
    assign diff_y = SPAN_W'(i_end_y) - SPAN_W'(i_start_y);
    assign abs_x  = diff_x < 0 ? SPAN_W'(-diff_x) : SPAN_W'(diff_x);
    assign abs_y  = diff_y < 0 ? SPAN_W'(-diff_y) : SPAN_W'(diff_y);

    assign e2     = {r_err, 1'b0};
    assign step_x = e2 > -$signed(E2_W'(r_span_y));
    assign step_y = e2 < $signed(E2_W'(r_span_x));
    assign n_err  = r_err - (step_x ? $signed(ERR_W'(r_span_y)) : '0)
                          + (step_y ? $signed(ERR_W'(r_span_x)) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_span_x <= '0;
            r_span_y <= '0;
            r_neg_x  <= 1'b0;
            r_neg_y  <= 1'b0;
            r_err    <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else if (i_start) begin
            r_cur_x  <= i_start_x;
            r_cur_y  <= i_start_y;
            r_tgt_x  <= i_end_x;
            r_tgt_y  <= i_end_y;
            r_span_x <= abs_x;
            r_span_y <= abs_y;
            r_neg_x  <= i_start_x > i_end_x;
            r_neg_y  <= i_start_y > i_end_y;
            r_err    <= $signed(ERR_W'(abs_x)) - $signed(ERR_W'(abs_y));
            r_color  <= i_ink;
            r_active <= 1'b1;
        end else if (i_tick && r_active) begin
            if (done) begin
                r_active <= 1'b0;
            end else begin
                r_err <= n_err;
                if (step_x) begin
                    r_cur_x <= r_neg_x ? r_cur_x - COORD_BITS'(1) : r_cur_x + COORD_BITS'(1);
                end
                if (step_y) begin
                    r_cur_y <= r_neg_y ? r_cur_y - COORD_BITS'(1) : r_cur_y + COORD_BITS'(1);
                end
            end
        end
    end

    assign o_plot = '{x: r_cur_x, y: r_cur_y, color: r_color, done: done, idle: !r_active};

endmodule

// ===== src/tblr_brush_emitter.sv =====
// ----------------------------------------------------------------------------
// tblr_brush_emitter : walks the square brush around one plotted point
// Holds the point of a tick, steps through the brush pixels row by row and
// places one pixel per cycle while the output is not stalled, with its clip
// flag and address, in the output register.
// ----------------------------------------------------------------------------
module tblr_brush_emitter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  tblr_pkg::t_plot                     i_plot,
    input  tblr_pkg::t_idx                      i_brush,
    input  tblr_pkg::t_canvas                   i_width,
    input  tblr_pkg::t_canvas                   i_height,
    input  logic                                i_out_stall,
    output logic                                o_ready,
    output logic                                o_out_valid,
    output logic signed [tblr_pkg::PIX_W-1:0]   o_pixel_x,
    output logic signed [tblr_pkg::PIX_W-1:0]   o_pixel_y,
    output logic [tblr_pkg::COLOR_W-1:0]        o_pixel_color,
    output logic [tblr_pkg::ADDR_W-1:0]         o_pixel_address,
    output logic                                o_inside_canvas,
    output logic                                o_last_of_tick,
    output logic                                o_line_done
);
    import tblr_pkg::*;

    localparam int FULL_W = COORD_BITS + 2;
    localparam int PROD_W = 2 * CANVAS_W;

    logic                       r_busy;
    t_plot                      r_plot;
    t_idx                       r_ix, r_iy;

    logic                       r_out_valid;
    logic signed [PIX_W-1:0]    r_px, r_py;
    logic [COLOR_W-1:0]         r_color;
    logic [ADDR_W-1:0]          r_addr;
    logic                       r_inside, r_last, r_done;

    t_idx                       half, last_ix;
    logic signed [IDX_W:0]      off_x, off_y;
    logic signed [FULL_W-1:0]   px_full, py_full, w_s, h_s;
    logic [PROD_W-1:0]          addr_full;
    logic                       on_canvas, last, out_free, fire;

    assign half    = i_brush >> 1;
    assign last_ix = i_brush - 1'b1;
    assign off_x   = $signed({1'b0, r_ix}) - $signed({1'b0, half});
    assign off_y   = $signed({1'b0, r_iy}) - $signed({1'b0, half});
    assign px_full = FULL_W'(r_plot.x) + FULL_W'(off_x);
    assign py_full = FULL_W'(r_plot.y) + FULL_W'(off_y);
    assign w_s     = $signed(FULL_W'(i_width));
    assign h_s     = $signed(FULL_W'(i_height));
    assign on_canvas = (px_full >= 0) && (py_full >= 0) && (px_full < w_s) && (py_full < h_s);
    assign addr_full = py_full[CANVAS_W-1:0] * i_width + PROD_W'(px_full[CANVAS_W-1:0]);

    assign last     = r_plot.idle || ((r_ix == last_ix) && (r_iy == last_ix));
    assign out_free = !r_out_valid || !i_out_stall;
    assign fire     = r_busy && out_free;
    assign o_ready  = !r_busy || (fire && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ix   <= '0;
            r_iy   <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_ix   <= '0;
            r_iy   <= '0;
        end else if (fire) begin
            if (last) begin
                r_busy <= 1'b0;
            end else if (r_ix == last_ix) begin
                r_ix <= '0;
                r_iy <= r_iy + 1'b1;
            end else begin
                r_ix <= r_ix + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_plot <= i_plot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // An idle tick gives a single all-zero pixel flagged as done.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_last <= last;
            r_done <= r_plot.done || r_plot.idle;
            if (r_plot.idle) begin
                r_px     <= '0;
                r_py     <= '0;
                r_color  <= '0;
                r_addr   <= '0;
                r_inside <= 1'b0;
            end else begin
                r_px     <= px_full[PIX_W-1:0];
                r_py     <= py_full[PIX_W-1:0];
                r_color  <= r_plot.color;
                r_addr   <= on_canvas ? addr_full[ADDR_W-1:0] : '0;
                r_inside <= on_canvas;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_pixel_color   = r_color;
    assign o_pixel_address = r_addr;
    assign o_inside_canvas = r_inside;
    assign o_last_of_tick  = r_last;
    assign o_line_done     = r_done;

endmodule

// ===== src/thick_brush_line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// thick_brush_line_rasterizer_unit : square-brush Bresenham line rasteriser
// Draws a line one point per tick word with a square brush, emitting one
// canvas pixel per result word with its byte address and a clip flag.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Word
//  in        sink       i_in_valid / o_in_stall    kind, end points, ink
//  out       source     o_out_valid / i_out_stall  one brush pixel
//  cfg       sink       i_cfg_we                   index, data
//
//  A tick word on a drawing engine produces the square of the clamped brush
//  size in result words, 1 to 16, at one per cycle while the output is not
//  stalled; the emitter's pixel counter sets the rate. An idle tick yields one
//  result word and a start word yields nothing. The next word is taken in the
//  cycle in which the last pixel of the current tick enters the output register,
//  so ticks follow one another with no gap. A stall on the output holds the
//  output register and, through it, the emitter and the input. Reset is
//  synchronous and leaves the engine idle with the register defaults loaded.
//
module thick_brush_line_rasterizer_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Configuration write port
    input  logic                                    i_cfg_we,
    input  logic [tblr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [tblr_pkg::CANVAS_W-1:0]           i_cfg_data,
    // Input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_kind,
    input  logic signed [tblr_pkg::COORD_BITS-1:0]  i_start_x,
    input  logic signed [tblr_pkg::COORD_BITS-1:0]  i_start_y,
    input  logic signed [tblr_pkg::COORD_BITS-1:0]  i_end_x,
    input  logic signed [tblr_pkg::COORD_BITS-1:0]  i_end_y,
    input  logic [tblr_pkg::COLOR_W-1:0]            i_ink,
    // Output channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [tblr_pkg::PIX_W-1:0]       o_pixel_x,
    output logic signed [tblr_pkg::PIX_W-1:0]       o_pixel_y,
    output logic [tblr_pkg::COLOR_W-1:0]            o_pixel_color,
    output logic [tblr_pkg::ADDR_W-1:0]             o_pixel_address,
    output logic                                    o_inside_canvas,
    output logic                                    o_last_of_tick,
    output logic                                    o_line_done
);
    import tblr_pkg::*;

    // Configuration registers, held as written; clamping happens on use.
    logic [BRUSH_W-1:0]  r_brush_size;
    t_canvas             r_canvas_width;
    t_canvas             r_canvas_height;

    t_idx     brush;
    t_canvas  width, height;
    t_plot    plot;
    logic     ready, accept, start, tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brush_size    <= BRUSH_W'(1);
            r_canvas_width  <= CANVAS_W'(480);
            r_canvas_height <= CANVAS_W'(260);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BRUSH_SIZE:    r_brush_size    <= i_cfg_data[BRUSH_W-1:0];
                CFG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg_data;
                CFG_CANVAS_HEIGHT: r_canvas_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A brush of zero is drawn as one pixel; oversized brushes saturate.
    always_comb begin
        if (r_brush_size == '0) begin
            brush = IDX_W'(1);
        end else if (r_brush_size > BRUSH_W'(MAX_BRUSH)) begin
            brush = IDX_W'(MAX_BRUSH);
        end else begin
            brush = IDX_W'(r_brush_size);
        end
    end

    assign width  = (r_canvas_width  > CANVAS_W'(CANVAS_MAX)) ? CANVAS_W'(CANVAS_MAX)
                                                              : r_canvas_width;
    assign height = (r_canvas_height > CANVAS_W'(CANVAS_MAX)) ? CANVAS_W'(CANVAS_MAX)
                                                              : r_canvas_height;

    // The emitter is free, or is handing over the last pixel of its tick.
    assign o_in_stall = !ready;
    assign accept     = i_in_valid && ready;
    assign start      = accept && (i_kind == KIND_START);
    assign tick       = accept && (i_kind == KIND_TICK);

    // The engine presents the point before stepping; the emitter captures it
    // in the same edge at which the engine advances.
    tblr_line_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_tick    (tick),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_ink     (i_ink),
        .o_plot    (plot)
    );

    tblr_brush_emitter u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (tick),
        .i_plot          (plot),
        .i_brush         (brush),
        .i_width         (width),
        .i_height        (height),
        .i_out_stall     (i_out_stall),
        .o_ready         (ready),
        .o_out_valid     (o_out_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_color   (o_pixel_color),
        .o_pixel_address (o_pixel_address),
        .o_inside_canvas (o_inside_canvas),
        .o_last_of_tick  (o_last_of_tick),
        .o_line_done     (o_line_done)
    );

endmodule

// ===== src/tblr_checker.sv =====
// ----------------------------------------------------------------------------
// tblr_checker : port-level checks of the line rasteriser
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module tblr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [tblr_pkg::PIX_W-1:0]   o_pixel_x,
    input  logic signed [tblr_pkg::PIX_W-1:0]   o_pixel_y,
    input  logic [tblr_pkg::ADDR_W-1:0]         o_pixel_address,
    input  logic                                o_inside_canvas,
    input  logic                                o_last_of_tick
);
    import tblr_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_pixel_address) && $stable(o_last_of_tick))
        else $error("result word changed while stalled");

    // No result word straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result word valid after reset");

    // Clipped pixels carry a zero address.
    a_clip_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_canvas |-> o_pixel_address == '0)
        else $error("clipped pixel with non-zero address");

    // A pixel on the canvas has non-negative coordinates.
    a_inside_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inside_canvas |-> o_pixel_x >= 0 && o_pixel_y >= 0)
        else $error("pixel flagged inside with negative coordinate");

endmodule

bind thick_brush_line_rasterizer_unit tblr_checker u_tblr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_pixel_x       (o_pixel_x),
    .o_pixel_y       (o_pixel_y),
    .o_pixel_address (o_pixel_address),
    .o_inside_canvas (o_inside_canvas),
    .o_last_of_tick  (o_last_of_tick)
);

// ===== sim/tb_thick_brush_line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_thick_brush_line_rasterizer_unit : self-checking bench of the line rasteriser
// Drives start and tick words through the valid/stall input channel under
// several brush and canvas settings. A scoreboard class predicts every brush
// pixel word and compares the output channel field by field, in order.
// ----------------------------------------------------------------------------
import tblr_pkg::*;

// One word of the input channel.
typedef struct {
    logic               kind;
    t_coord             sx;
    t_coord             sy;
    t_coord             ex;
    t_coord             ey;
    logic [COLOR_W-1:0] ink;
} t_raster_word;

// One word of the output channel, in port order.
typedef struct {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [COLOR_W-1:0]      color;
    logic [ADDR_W-1:0]       addr;
    logic                    in_canvas;
    logic                    last;
    logic                    done;
} t_brush_pixel;

class brush_pixel_scoreboard;
    // Register copies, as written (saturation is applied when a tick is drawn).
    int brush_reg  = 1;
    int width_reg  = 480;
    int height_reg = 260;

    // Line engine state.
    int                 pos_x, pos_y, goal_x, goal_y, run_x, run_y, slope_err;
    bit                 back_x, back_y, drawing;
    logic [COLOR_W-1:0] colour;

    t_brush_pixel expected_pixels[$];
    int errors, starts, ticks, idle_ticks, lines_ended, pixels, inside_pixels;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CANVAS_W-1:0] data);
        case (idx)
            CFG_BRUSH_SIZE:    brush_reg  = int'(data[BRUSH_W-1:0]);
            CFG_CANVAS_WIDTH:  width_reg  = int'(data);
            CFG_CANVAS_HEIGHT: height_reg = int'(data);
            default: ;
        endcase
    endfunction

    // Works out the pixel words that one accepted input word causes.
    function void take_word(t_raster_word wd);
        int           b, h, lim_w, lim_h, px, py, e2, addr_v;
        bit           fin, on_canvas;
        t_brush_pixel p;
        if (wd.kind == KIND_START) begin
            pos_x     = wd.sx;
            pos_y     = wd.sy;
            goal_x    = wd.ex;
            goal_y    = wd.ey;
            colour    = wd.ink;
            run_x     = (goal_x > pos_x) ? goal_x - pos_x : pos_x - goal_x;
            run_y     = (goal_y > pos_y) ? goal_y - pos_y : pos_y - goal_y;
            back_x    = pos_x > goal_x;
            back_y    = pos_y > goal_y;
            slope_err = run_x - run_y;
            drawing   = 1'b1;
            starts++;
            return;
        end
        ticks++;
        if (!drawing) begin
            p = '{default: '0};
            p.last = 1'b1;
            p.done = 1'b1;
            expected_pixels.push_back(p);
            idle_ticks++;
            return;
        end
        b = brush_reg;
        if (b < 1) b = 1;
        if (b > MAX_BRUSH) b = MAX_BRUSH;
        h     = b / 2;
        lim_w = (width_reg > CANVAS_MAX) ? CANVAS_MAX : width_reg;
        lim_h = (height_reg > CANVAS_MAX) ? CANVAS_MAX : height_reg;
        fin   = (pos_x == goal_x) && (pos_y == goal_y);
        for (int dy = -h; dy < b - h; dy++) begin
            for (int dx = -h; dx < b - h; dx++) begin
                px          = pos_x + dx;
                py          = pos_y + dy;
                on_canvas   = px >= 0 && py >= 0 && px < lim_w && py < lim_h;
                addr_v      = py * lim_w + px;
                p.x         = px[PIX_W-1:0];
                p.y         = py[PIX_W-1:0];
                p.color     = colour;
                p.addr      = on_canvas ? addr_v[ADDR_W-1:0] : '0;
                p.in_canvas = on_canvas;
                p.last      = (dy == b - h - 1) && (dx == b - h - 1);
                p.done      = fin;
                expected_pixels.push_back(p);
                pixels++;
                if (on_canvas) inside_pixels++;
            end
        end
        if (fin) begin
            drawing = 1'b0;
            lines_ended++;
        end else begin
            e2 = slope_err * 2;
            if (e2 > -run_y) begin
                slope_err -= run_y;
                pos_x += back_x ? -1 : 1;
            end
            if (e2 < run_x) begin
                slope_err += run_x;
                pos_y += back_y ? -1 : 1;
            end
        end
    endfunction

    function void compare_field(string name, logic signed [31:0] want_v,
                                logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    function void check_pixel(t_brush_pixel got);
        t_brush_pixel want;
        if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: pixel word with nothing expected, got x %0d y %0d",
                     $time, got.x, got.y);
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("pixel_x",       want.x,         got.x);
        compare_field("pixel_y",       want.y,         got.y);
        compare_field("pixel_color",   want.color,     got.color);
        compare_field("pixel_address", want.addr,      got.addr);
        compare_field("inside_canvas", want.in_canvas, got.in_canvas);
        compare_field("last_of_tick",  want.last,      got.last);
        compare_field("line_done",     want.done,      got.done);
    endfunction
endclass

module tb_thick_brush_line_rasterizer_unit;

    // The receiver's one long hold-off, long enough to back the block up to its input.
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles with no word moving on any port before the run is declared hung.
    localparam int STUCK_LIMIT     = 4000;
    localparam int WORDS_PER_PHASE = 35;
    // A start word yields nothing, so the engine is given settling time before
    // registers change or the run ends.
    localparam int SETTLE_CYCLES   = 8;
    localparam int NUM_PHASES      = 9;

    // Register settings per phase; a negative canvas size means a random one.
    // Brush sizes zero, five and seven and canvas size 2047 are the out-of-range
    // settings that the block must saturate; a zero canvas size clips every pixel.
    localparam int PHASE_BRUSH  [NUM_PHASES] = '{3, 4, 1, 2, 0, 7, 5, 3, 4};
    localparam int PHASE_WIDTH  [NUM_PHASES] = '{480, 1024, 1, 2047, 0, 640, 100, -1, 64};
    localparam int PHASE_HEIGHT [NUM_PHASES] = '{260, 1024, 1, 2047, 37, 0, 100, -1, 48};

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CANVAS_W-1:0]      i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_kind;
    t_coord                   i_start_x;
    t_coord                   i_start_y;
    t_coord                   i_end_x;
    t_coord                   i_end_y;
    logic [COLOR_W-1:0]       i_ink;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [PIX_W-1:0]  o_pixel_x;
    logic signed [PIX_W-1:0]  o_pixel_y;
    logic [COLOR_W-1:0]       o_pixel_color;
    logic [ADDR_W-1:0]        o_pixel_address;
    logic                     o_inside_canvas;
    logic                     o_last_of_tick;
    logic                     o_line_done;

    brush_pixel_scoreboard sb = new();
    t_brush_pixel          seen_pixel;
    bit                    calm;
    bit                    hold_req;
    int                    stuck_cycles = 0;

    thick_brush_line_rasterizer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_ink           (i_ink),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_color   (o_pixel_color),
        .o_pixel_address (o_pixel_address),
        .o_inside_canvas (o_inside_canvas),
        .o_last_of_tick  (o_last_of_tick),
        .o_line_done     (o_line_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Gap length shared by the sender and the receiver: mostly none or short,
    // now and then long. In a calm phase neither side idles at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_coord(int v);
        if (v > 2047) return 2047;
        if (v < -2048) return -2048;
        return v;
    endfunction

    // Mostly near the canvas, so that brushes straddle its edges; otherwise
    // anywhere in the coordinate range or hard against its ends.
    function automatic int pick_coord(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, lim + 6) - 3;
        if (r < 85) return $urandom_range(0, 4095) - 2048;
        if (r < 93) return 2047 - $urandom_range(0, 3);
        return $urandom_range(0, 3) - 2048;
    endfunction

    function automatic t_raster_word line_word(int sx, int sy, int ex, int ey, int ink);
        t_raster_word wd;
        wd.kind = KIND_START;
        wd.sx   = t_coord'(sx);
        wd.sy   = t_coord'(sy);
        wd.ex   = t_coord'(ex);
        wd.ey   = t_coord'(ey);
        wd.ink  = ink[COLOR_W-1:0];
        return wd;
    endfunction

    // The start point, end point and ink fields of a tick are ignored, so they carry noise.
    function automatic t_raster_word tick_word();
        t_raster_word wd;
        wd.kind = KIND_TICK;
        wd.sx   = t_coord'($urandom);
        wd.sy   = t_coord'($urandom);
        wd.ex   = t_coord'($urandom);
        wd.ey   = t_coord'($urandom);
        wd.ink  = COLOR_W'($urandom);
        return wd;
    endfunction

    // Offers one word after a random gap and holds it until the block takes it.
    task automatic send_word(t_raster_word wd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind     <= wd.kind;
        i_start_x  <= wd.sx;
        i_start_y  <= wd.sy;
        i_end_x    <= wd.ex;
        i_end_y    <= wd.ey;
        i_ink      <= wd.ink;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_word(wd);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(tick_word());
    endtask

    // Writes all three registers on consecutive cycles. The brush register is
    // three bits wide, so the upper data bits carry noise that it must ignore.
    task automatic write_settings(int brush, int width, int height);
        logic [CANVAS_W-1:0] brush_data;
        brush_data = CANVAS_W'(($urandom_range(0, 255) << BRUSH_W) | brush);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BRUSH_SIZE;
        i_cfg_data  <= brush_data;
        @(posedge i_clk) sb.set_register(CFG_BRUSH_SIZE, brush_data);
        @(negedge i_clk);
        i_cfg_index <= CFG_CANVAS_WIDTH;
        i_cfg_data  <= CANVAS_W'(width);
        @(posedge i_clk) sb.set_register(CFG_CANVAS_WIDTH, CANVAS_W'(width));
        @(negedge i_clk);
        i_cfg_index <= CFG_CANVAS_HEIGHT;
        i_cfg_data  <= CANVAS_W'(height);
        @(posedge i_clk) sb.set_register(CFG_CANVAS_HEIGHT, CANVAS_W'(height));
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // The sender stops and waits for every predicted pixel word to come out.
    task automatic wait_drained();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        // A tick on an idle engine gives one empty word with line_done set.
        send_ticks(1);
        // A line of one point ends on its first tick; the next tick finds it idle.
        send_word(line_word(0, 0, 0, 0, 8'hFF));
        send_ticks(2);
        // Top end of the coordinate range, with the brush reaching past it.
        send_word(line_word(2047, 2047, 2047, 2045, 8'h00));
        send_ticks(3);
        // Bottom end of the coordinate range.
        send_word(line_word(-2048, -2048, -2047, -2048, 8'hA5));
        send_ticks(2);
        // A line dropped half way by a new start word.
        send_word(line_word(5, 5, 9, 7, 8'h3C));
        send_ticks(2);
        // Across the far corner of the canvas, so the brush is partly clipped.
        send_word(line_word(479, 259, 477, 258, 8'h5A));
        send_ticks(3);
        // A steep line stepping back in both axes.
        send_word(line_word(10, 20, 8, 15, 8'hC3));
        send_ticks(6);
    endtask

    // Mostly whole short lines with random content. Some are cut short by the
    // next start, some run on into idle ticks, and some head off to a far
    // point and are dropped after a few ticks.
    task automatic run_random(int budget);
        int made, lim_x, lim_y, r, sx, sy, ex, ey, len;
        made  = 0;
        lim_x = (sb.width_reg > CANVAS_MAX) ? CANVAS_MAX : sb.width_reg;
        lim_y = (sb.height_reg > CANVAS_MAX) ? CANVAS_MAX : sb.height_reg;
        while (made < budget) begin
            r  = $urandom_range(0, 99);
            sx = pick_coord(lim_x);
            sy = pick_coord(lim_y);
            if (r < 12) begin
                ex  = $urandom_range(0, 4095) - 2048;
                ey  = $urandom_range(0, 4095) - 2048;
                len = $urandom_range(1, 4);
            end else begin
                ex  = clamp_coord(sx + $urandom_range(0, 12) - 6);
                ey  = clamp_coord(sy + $urandom_range(0, 12) - 6);
                len = (ex > sx) ? ex - sx : sx - ex;
                if (((ey > sy) ? ey - sy : sy - ey) > len)
                    len = (ey > sy) ? ey - sy : sy - ey;
                len = len + 1;
                if (r < 25)
                    len = $urandom_range(0, len - 1);
                else if (r < 35)
                    len = len + $urandom_range(1, 2);
            end
            send_word(line_word(sx, sy, ex, ey, $urandom_range(0, 255)));
            send_ticks(len);
            made += len + 1;
        end
    endtask

    // Stimulus and the end of the run.
    initial begin
        int width, height;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_kind      = KIND_START;
        i_start_x   = '0;
        i_start_y   = '0;
        i_end_x     = '0;
        i_end_y     = '0;
        i_ink       = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            width  = (PHASE_WIDTH[ph] < 0) ? $urandom_range(1, 1024) : PHASE_WIDTH[ph];
            height = (PHASE_HEIGHT[ph] < 0) ? $urandom_range(1, 1024) : PHASE_HEIGHT[ph];
            write_settings(PHASE_BRUSH[ph], width, height);
            // Phase three runs flat out on both sides; phase one carries the
            // receiver's long hold-off while the sender keeps offering words.
            calm     = (ph == 3);
            hold_req = (ph == 1);
            if (ph == 0)
                run_directed();
            else
                run_random(WORDS_PER_PHASE);
            wait_drained();
        end
        repeat (20) @(posedge i_clk);

        $display("Covered %0d words: %0d line starts and %0d ticks, %0d of them on an idle engine,",
                 sb.starts + sb.ticks, sb.starts, sb.ticks, sb.idle_ticks);
        $display("%0d pixel words (%0d on the canvas), %0d lines to the end, %0d settings.",
                 sb.pixels, sb.inside_pixels, sb.lines_ended, NUM_PHASES);
        if (sb.errors == 0) begin
            $display("tb_thick_brush_line_rasterizer_unit: done, clean");
        end else begin
            $display("tb_thick_brush_line_rasterizer_unit: done, errors");
        end
        $finish;
    end

    // Receiver: open stretches of random length broken by stalls of random
    // length, plus one long hold-off on request so that the block backs up.
    initial begin
        int open_len, shut_len;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk) i_out_stall <= 1'b1;
            end
            open_len = $urandom_range(1, 24);
            repeat (open_len) @(negedge i_clk) i_out_stall <= 1'b0;
            shut_len = pick_gap();
            repeat (shut_len) @(negedge i_clk) i_out_stall <= 1'b1;
        end
    end

    // Result check and watchdog. Both sample at the rising edge, when every
    // input has been steady since the falling edge before it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen_pixel.x         = o_pixel_x;
                seen_pixel.y         = o_pixel_y;
                seen_pixel.color     = o_pixel_color;
                seen_pixel.addr      = o_pixel_address;
                seen_pixel.in_canvas = o_inside_canvas;
                seen_pixel.last      = o_last_of_tick;
                seen_pixel.done      = o_line_done;
                sb.check_pixel(seen_pixel);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles == STUCK_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d pixel words still awaited",
                         $time, STUCK_LIMIT, sb.expected_pixels.size());
                $display("tb_thick_brush_line_rasterizer_unit: done, errors");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

endmodule
